@@ rtl/lssk_pkg.sv @@
// ----------------------------------------------------------------------------
// lssk_pkg: shared definitions for the longest subarray sum block
// Sizes, hash constants and the layout of one hash table slot.
// ----------------------------------------------------------------------------
package lssk_pkg;

	localparam int MAX_ITEMS   = 1024;
	// The slot number is taken from the hash bits, so the table depth is a power of two.
	localparam int TABLE_SLOTS = 2048;

	localparam int DATA_W      = 32;
	localparam int KEY_W       = 48;
	localparam int BEST_W      = 11;
	localparam int OUT_TDATA_W = ((BEST_W + 7) / 8) * 8;
	localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int EPOCH_W     = 8;

	// The slot is bits [HASH_SHIFT +: SLOT_W] of key * HASH_MULT, so only the
	// low HASH_W bits of the product are needed.
	localparam int HASH_SHIFT  = 32;
	localparam int HASH_W      = HASH_SHIFT + SLOT_W;
	localparam int LO_W        = (HASH_W + 1) / 2;
	localparam int HI_W        = HASH_W - LO_W;

	localparam logic [63:0]     HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [LO_W-1:0] MULT_LO   = HASH_MULT[LO_W-1:0];
	localparam logic [HI_W-1:0] MULT_HI   = HASH_MULT[HASH_W-1:LO_W];

	// Epoch zero marks a slot that is free in every array.
	localparam logic [EPOCH_W-1:0] EPOCH_FREE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] pos;
	} slot_entry_t;

	typedef struct packed {
		logic               rd_en;
		logic [SLOT_W-1:0]  rd_addr;
		logic               wr_en;
		logic [SLOT_W-1:0]  wr_addr;
		slot_entry_t        wr_data;
	} table_req_t;

endpackage

@@ rtl/lssk_hash.sv @@
// ----------------------------------------------------------------------------
// lssk_hash: multiplicative hash of a prefix sum key
// One narrow multiplier is reused over three steps to form the low bits of
// key * HASH_MULT; the slot number is read from the finished accumulator.
// ----------------------------------------------------------------------------
module lssk_hash import lssk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [KEY_W-1:0] key,
	output logic                    done,
	output logic [SLOT_W-1:0]       slot
);

	localparam logic [1:0] STEP_LOW   = 2'd0;
	localparam logic [1:0] STEP_CROSS = 2'd1;
	localparam logic [1:0] STEP_HIGH  = 2'd2;

	logic [63:0]       key_ext;
	logic [LO_W-1:0]   key_lo_q;
	logic [HI_W-1:0]   key_hi_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [HASH_W-1:0] acc_q;
	logic [LO_W-1:0]   op_a;
	logic [LO_W-1:0]   op_b;
	logic [2*LO_W-1:0] prod;
	logic [HASH_W-1:0] cross_term;

	assign key_ext = 64'(key);

	always_comb begin
		case (step_q)
			STEP_LOW: begin
				op_a = key_lo_q;
				op_b = MULT_LO;
			end
			STEP_CROSS: begin
				op_a = LO_W'(key_hi_q);
				op_b = MULT_LO;
			end
			STEP_HIGH: begin
				op_a = key_lo_q;
				op_b = LO_W'(MULT_HI);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod       = op_a * op_b;
	// The cross products only reach the kept bits through their low HI_W bits.
	assign cross_term = {prod[HI_W-1:0], {LO_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			step_q   <= STEP_LOW;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			acc_q    <= '0;
		end else if (start) begin
			key_lo_q <= key_ext[LO_W-1:0];
			key_hi_q <= key_ext[HASH_W-1:LO_W];
			step_q   <= STEP_LOW;
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
		end else if (busy_q) begin
			case (step_q)
				STEP_LOW: begin
					acc_q  <= prod[HASH_W-1:0];
					step_q <= STEP_CROSS;
				end
				STEP_CROSS: begin
					acc_q  <= acc_q + cross_term;
					step_q <= STEP_HIGH;
				end
				STEP_HIGH: begin
					acc_q  <= acc_q + cross_term;
					step_q <= STEP_LOW;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				default: begin
					step_q <= STEP_LOW;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign slot = acc_q[HASH_W-1:HASH_SHIFT];

endmodule

@@ rtl/lssk_table.sv @@
// ----------------------------------------------------------------------------
// lssk_table: hash table slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lssk_table import lssk_pkg::*; (
	input  logic        clk,
	input  table_req_t  req,
	output slot_entry_t rd_data
);

	slot_entry_t mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

@@ rtl/longest_subarray_sum_k.sv @@
// ----------------------------------------------------------------------------
// longest_subarray_sum_k: longest run of elements summing to a target
// Prefix sums are kept in a linear probe hash table holding first positions.
// ----------------------------------------------------------------------------
// The input stream carries one signed 32-bit element per beat in s_axis_tdata,
// with s_axis_tlast on the final element of an array. Every input beat gives
// exactly one output beat: the best length so far in m_axis_tdata, tlast
// copied from the input and tuser set once the array has gone past MAX_ITEMS
// elements (the excess elements are ignored). target_sum is to be written
// through cfg_valid/cfg_data while the block is idle; the block itself does
// not enforce this. It is kept across arrays. Each element takes a lookup
// pass and an insert pass, each of which hashes its key and then reads and
// compares slots one by one until the probe ends. A zero lookup key skips
// the hashing and probing of the lookup pass, and a zero prefix sum skips
// the insert pass; an excess element goes straight to its result. The next
// element is taken once the result is registered, even while that result
// still waits in the output register; a stalled receiver holds the block
// once a second result is ready. After reset, and after every 255th array,
// a clearing pass sweeps all TABLE_SLOTS (2048) slots while no input is taken.
// Between arrays the table is emptied by moving to a new epoch, at no cost.
// ----------------------------------------------------------------------------
module longest_subarray_sum_k import lssk_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: target_sum
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [DATA_W-1:0]      cfg_data,
	// tdata: value[31:0]
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [DATA_W-1:0]      s_axis_tdata,
	input  logic                   s_axis_tlast,
	// tdata: best_len[10:0], zero filled above; tlast: done_res
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast,
	// tuser: overflow[0]
	output logic                   m_axis_tuser
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WANT  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_HASH  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_CMP   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic PH_LOOKUP = 1'b0;
	localparam logic PH_INSERT = 1'b1;

	logic [2:0]               state_q;
	logic                     phase_q;
	logic signed [DATA_W-1:0] target_q;
	logic signed [KEY_W-1:0]  prefix_q;
	logic signed [KEY_W-1:0]  key_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       best_q;
	logic                     ovf_q;
	logic                     last_q;
	logic [EPOCH_W-1:0]       epoch_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        probe_q;
	logic [SLOT_W-1:0]        clr_q;

	logic                     out_valid_q;
	logic [COUNT_W-1:0]       out_best_q;
	logic                     out_last_q;
	logic                     out_ovf_q;

	logic                     in_beat;
	logic                     out_load;
	logic                     hash_start;
	logic                     hash_done;
	logic [SLOT_W-1:0]        hash_slot;
	logic                     key_zero;
	logic                     slot_live;
	logic                     key_match;
	logic [COUNT_W-1:0]       run_len;
	table_req_t               tbl_req;
	slot_entry_t              tbl_rd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign key_zero   = (key_q == '0);
	assign hash_start = (state_q == ST_CHECK) && !(phase_q == PH_LOOKUP && key_zero);
	assign slot_live  = (tbl_rd.epoch == epoch_q);
	assign key_match  = (tbl_rd.key == key_q);
	assign run_len    = count_q - tbl_rd.pos;

	lssk_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	always_comb begin
		tbl_req         = '0;
		tbl_req.rd_en   = (state_q == ST_READ);
		tbl_req.rd_addr = slot_q;
		if (state_q == ST_CLEAR) begin
			tbl_req.wr_en         = 1'b1;
			tbl_req.wr_addr       = clr_q;
			tbl_req.wr_data.epoch = EPOCH_FREE;
		end else if (state_q == ST_CMP && phase_q == PH_INSERT && !slot_live) begin
			tbl_req.wr_en         = 1'b1;
			tbl_req.wr_addr       = slot_q;
			tbl_req.wr_data.epoch = epoch_q;
			tbl_req.wr_data.key   = key_q;
			tbl_req.wr_data.pos   = count_q;
		end
	end

	lssk_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (tbl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_LOOKUP;
			prefix_q    <= '0;
			key_q       <= '0;
			count_q     <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			epoch_q     <= EPOCH_FIRST;
			slot_q      <= '0;
			probe_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_best_q  <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						last_q <= s_axis_tlast;
						if (count_q >= COUNT_W'(MAX_ITEMS)) begin
							ovf_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							count_q  <= count_q + 1'b1;
							prefix_q <= prefix_q + KEY_W'(signed'(s_axis_tdata));
							phase_q  <= PH_LOOKUP;
							state_q  <= ST_WANT;
						end
					end
				end
				ST_WANT: begin
					key_q   <= prefix_q - KEY_W'(target_q);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (phase_q == PH_LOOKUP && key_zero) begin
						// Prefix zero sits at position 0 and is never stored.
						if (count_q > best_q) begin
							best_q <= count_q;
						end
						if (prefix_q != '0) begin
							key_q   <= prefix_q;
							phase_q <= PH_INSERT;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						slot_q  <= hash_slot;
						probe_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!slot_live || key_match || probe_q == '1) begin
						// Probe ends: free slot, hit, or every slot visited.
						if (phase_q == PH_LOOKUP) begin
							if (slot_live && key_match && run_len > best_q) begin
								best_q <= run_len;
							end
							if (prefix_q != '0) begin
								key_q   <= prefix_q;
								phase_q <= PH_INSERT;
								state_q <= ST_CHECK;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_best_q  <= best_q;
						out_last_q  <= last_q;
						out_ovf_q   <= ovf_q;
						if (last_q) begin
							prefix_q <= '0;
							count_q  <= '0;
							best_q   <= '0;
							ovf_q    <= 1'b0;
							if (epoch_q == EPOCH_LAST) begin
								// Old epochs would come back into use: sweep the table.
								epoch_q <= EPOCH_FIRST;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_best_q[BEST_W-1:0]);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	a_best_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= count_q)
		else $error("best length exceeds element count");

	a_overflow_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == COUNT_W'(MAX_ITEMS))
		else $error("overflow flagged below the element limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_q |=> count_q == '0 && best_q == '0 && !ovf_q)
		else $error("array state not cleared after last element");

	a_insert_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en && state_q != ST_CLEAR |-> key_q != '0 && epoch_q != EPOCH_FREE)
		else $error("table insert of zero key or free epoch");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready && state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for longest_subarray_sum_k
// Streams arrays of signed elements under several target sums and compares
// every output beat with a predictor that tracks prefix sums and the first
// position of each one in its own associative table.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lssk_pkg::*;

	localparam int     HOLD_MAX       = 18;
	localparam int     SETTLE_CYCLES  = 24;
	localparam int     WATCHDOG_LIMIT = 50000;
	localparam int     PHASE_COUNT    = 8;
	localparam int     PHASE_ITEMS    = 110;
	localparam int     LONG_PHASE     = 3;
	localparam int     LONG_LEN       = MAX_ITEMS + 3;
	localparam longint KEY_LOW        = -(longint'(1) <<< (KEY_W - 1));
	localparam longint KEY_HIGH       = (longint'(1) <<< (KEY_W - 1)) - 1;

	typedef enum {VAL_SMALL, VAL_NEAR_TARGET, VAL_WIDE} value_mode_e;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
	} element_t;

	typedef struct packed {
		logic [BEST_W-1:0] best_len;
		logic              done_res;
		logic              overflow;
	} result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [DATA_W-1:0]      cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// tdata: value[31:0]
	logic [DATA_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// tdata: best_len[10:0], zeros above
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	// tuser: overflow[0]
	logic                   m_axis_tuser;

	longest_subarray_sum_k u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state, mirroring the block's view of the current array.
	logic signed [DATA_W-1:0] target_now = '0;
	longint                   prefix_acc = 0;
	int unsigned              elem_count = 0;
	int unsigned              best_run = 0;
	bit                       array_overflow = 1'b0;
	int unsigned              first_seen_pos [longint];

	element_t elem_queue [$];
	result_t  expected_results [$];
	int       items_outstanding = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       in_hold = 0;
	int       out_hold = 0;
	bit       in_calm = 1'b0;
	bit       out_calm = 1'b0;

	function automatic int draw_hold(inout bit calm);
		// Occasionally switch between random holds and running flat out.
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, HOLD_MAX);
	endfunction

	function automatic void predict_best_len(input logic signed [DATA_W-1:0] elem,
			input logic is_last);
		longint      want_key;
		int unsigned pos;
		result_t     r;
		if (elem_count >= MAX_ITEMS) begin
			array_overflow = 1'b1;
		end else begin
			pos = elem_count + 1;
			elem_count = pos;
			prefix_acc += longint'(elem);
			want_key = prefix_acc - longint'(target_now);
			// A zero key matches the empty prefix sitting before position 1.
			if (want_key == 0) begin
				if (pos > best_run)
					best_run = pos;
			end else if (want_key >= KEY_LOW && want_key <= KEY_HIGH &&
					first_seen_pos.exists(want_key)) begin
				if (pos - first_seen_pos[want_key] > best_run)
					best_run = pos - first_seen_pos[want_key];
			end
			if (prefix_acc != 0 && !first_seen_pos.exists(prefix_acc))
				first_seen_pos[prefix_acc] = pos;
		end
		r.best_len = BEST_W'(best_run);
		r.done_res = is_last;
		r.overflow = array_overflow;
		expected_results.insert(expected_results.size(), r);
		if (is_last) begin
			prefix_acc = 0;
			elem_count = 0;
			best_run = 0;
			array_overflow = 1'b0;
			first_seen_pos.delete();
		end
	endfunction

	function automatic void queue_elem(input logic [DATA_W-1:0] value, input logic last);
		element_t e;
		e.value = value;
		e.last = last;
		elem_queue.insert(elem_queue.size(), e);
		items_outstanding++;
	endfunction

	function automatic void queue_array(input int len, input value_mode_e mode);
		logic [DATA_W-1:0] v;
		int                pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			case (mode)
				VAL_SMALL: begin
					v = DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
				end
				VAL_NEAR_TARGET: begin
					// Elements equal to the target, or its negation, make hits likely.
					if (pick < 3)
						v = target_now;
					else if (pick < 5)
						v = -target_now;
					else
						v = DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
				end
				default: begin
					if (pick == 0)
						v = 32'h8000_0000;
					else if (pick == 1)
						v = 32'h7fff_ffff;
					else
						v = $urandom();
				end
			endcase
			queue_elem(v, i == len - 1);
		end
	endfunction

	task automatic wait_drained();
		while (items_outstanding != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [DATA_W-1:0] k);
		wait_drained();
		cfg_data <= k;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		target_now = k;
	endtask

	// Element driver.
	always @(posedge clk or negedge arst_n) begin : driver
		element_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_best_len(s_axis_tdata, s_axis_tlast);
				items_outstanding--;
				in_hold = draw_hold(in_calm);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (in_hold > 0) begin
					in_hold--;
					s_axis_tvalid <= 1'b0;
				end else if (elem_queue.size() != 0) begin
					nxt = elem_queue.pop_front();
					s_axis_tdata <= nxt.value;
					s_axis_tlast <= nxt.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker.
	always @(posedge clk or negedge arst_n) begin : monitor
		result_t oldest;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: best_len %0d", m_axis_tdata);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					if (m_axis_tdata !== OUT_TDATA_W'(oldest.best_len)) begin
						$error("best_len: expected %0d, actual %0d",
							oldest.best_len, m_axis_tdata);
						mismatches++;
					end
					if (m_axis_tlast !== oldest.done_res) begin
						$error("done_res: expected %0b, actual %0b",
							oldest.done_res, m_axis_tlast);
						mismatches++;
					end
					if (m_axis_tuser !== oldest.overflow) begin
						$error("overflow: expected %0b, actual %0b",
							oldest.overflow, m_axis_tuser);
						mismatches++;
					end
				end
				out_hold = draw_hold(out_calm);
			end else if (out_hold > 0) begin
				out_hold--;
			end
			m_axis_tready <= (out_hold == 0);
		end
	end

	// The clearing sweep after reset and after many arrays shows no beats, but it
	// ends well inside the limit.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [DATA_W-1:0] target_plan [PHASE_COUNT];
		value_mode_e       mode;
		int                left;
		int                len;
		int                pick;

		target_plan = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1,
			32'hffff_ffff, 32'd7, 32'h0, 32'h0};
		target_plan[6] = $urandom();
		target_plan[7] = DATA_W'($urandom_range(0, 40)) - DATA_W'(20);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed arrays with the reset target of zero: zero elements, both
		// extremes, a prefix returning to zero and a single-element array.
		queue_elem(32'h0, 1'b0);
		queue_elem(32'd5, 1'b0);
		queue_elem(-32'd5, 1'b0);
		queue_elem(32'h7fff_ffff, 1'b0);
		queue_elem(32'h8000_0000, 1'b0);
		queue_elem(32'd1, 1'b1);
		queue_elem(32'h8000_0000, 1'b1);
		queue_elem(32'd1, 1'b0);
		queue_elem(32'd2, 1'b0);
		queue_elem(-32'd3, 1'b0);
		queue_elem(32'd4, 1'b1);
		queue_elem(32'h7fff_ffff, 1'b0);
		queue_elem(32'h7fff_ffff, 1'b0);
		queue_elem(32'h7fff_ffff, 1'b1);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_target(target_plan[p]);
			// One array runs past the element limit, with its last flag on an
			// ignored element.
			if (p == LONG_PHASE)
				queue_array(LONG_LEN, VAL_SMALL);
			left = PHASE_ITEMS;
			while (left > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					len = $urandom_range(1, 2);
				else if (pick < 92)
					len = $urandom_range(3, 6);
				else
					len = $urandom_range(7, 24);
				if (len > left)
					len = left;
				pick = $urandom_range(0, 9);
				if (pick < 5)
					mode = VAL_SMALL;
				else if (pick < 8)
					mode = VAL_NEAR_TARGET;
				else
					mode = VAL_WIDE;
				queue_array(len, mode);
				left -= len;
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
